// ===== src/top_k_rssi_tracker_top_macros.svh =====
// Assertion macros used by the checker file of the ranked RSSI tracker.
`ifndef TOP_K_RSSI_TRACKER_TOP_MACROS_SVH
`define TOP_K_RSSI_TRACKER_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define TKRT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TKRT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tkrt_pkg.sv =====
// Shared types and constants of the ranked RSSI tracker.
`timescale 1ns / 1ps

package tkrt_pkg;

   localparam int TOP_COUNT_DEF = 8;

   localparam int RSSI_W        = 8;
   localparam int FREQ_W        = 16;
   localparam int RANK_W        = 3;

   localparam int REQ_TDATA_W   = RSSI_W + FREQ_W;
   localparam int RSP_FIELDS_W  = RANK_W + FREQ_W + RSSI_W;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [RSSI_W-1:0] strength;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== src/top_k_rssi_tracker_top.sv =====
// Top level of the ranked RSSI tracker: keeps the strongest readings of a scan.
`timescale 1ns / 1ps

// Usage
//   req channel: one beat per scanned channel. tdata carries the strength and
//   frequency, tuser marks the first channel of a scan (table is emptied before
//   the insert), tlast marks the last channel (table is sent after the insert).
//   rsp channel: on a last channel, TOP_COUNT beats in rank order, strongest
//   first; tlast rides on the final rank. Empty ranks come out as zeros.
// Timing
//   The table lives in one RAM with a registered read. An accepted beat starts a
//   read-modify-write sweep over all ranks; no new beat is taken until it ends,
//   so a beat without tlast can be followed once the sweep is through.
//   The RAM read port then walks the table again for output, one rank at a
//   time: each rank is read in ST_EMIT_RD and loaded into the output register
//   in ST_EMIT_WAIT, as long as the output register is free or rsp_tready is high.
// Reset
//   Reset empties the table at once through a table-valid flag (no clearing
//   pass), drops any pending result and returns to idle.
// Stalls
//   A stalled result holds in the output register; the walk pauses until it
//   is taken. Once the final rank is loaded the block takes new beats again.
module top_k_rssi_tracker_top
   import tkrt_pkg::*;
#(
   parameter int TOP_COUNT = TOP_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // input beats
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [7:0] rssi_value, [23:8] channel_frequency
   input  logic [0:0]             req_tuser,  // [0] first_of_scan
   input  logic                   req_tlast,  // last_of_scan
   // result beats
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [2:0] rank_index, [18:3] top_frequency,
                                              // [26:19] top_rssi, [31:27] zero
   output logic                   rsp_tlast   // last_entry
);

   localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TOP_COUNT - 1);
   localparam int PAD_W = RSP_TDATA_W - RSP_FIELDS_W;

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_SWEEP     = 2'd1;
   localparam logic [1:0] ST_EMIT_RD   = 2'd2;
   localparam logic [1:0] ST_EMIT_WAIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   entry_type              new_ff, new_in;
   entry_type              carry_ff, carry_in;
   logic                   inserted_ff, inserted_in;
   logic                   clear_ff, clear_in;
   logic                   last_ff, last_in;
   logic                   table_valid_ff, table_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   entry_type              ram_wr_data;
   logic                   ram_rd_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   entry_type              ram_rd_data;
   entry_type              eff_entry;
   logic                   req_fire;

   tkrt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TOP_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // A cleared table (first of scan, or nothing written since reset) reads as zeros.
   assign eff_entry = clear_ff ? '0 : ram_rd_data;

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      new_in         = new_ff;
      carry_in       = carry_ff;
      inserted_in    = inserted_ff;
      clear_in       = clear_ff;
      last_in        = last_ff;
      table_valid_in = table_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = pos_ff;
      ram_wr_data    = eff_entry;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // latch the reading and fetch rank 0
               new_in.strength = req_tdata[RSSI_W-1:0];
               new_in.freq     = req_tdata[REQ_TDATA_W-1:RSSI_W];
               clear_in        = req_tuser[0] || !table_valid_ff;
               last_in         = req_tlast;
               inserted_in     = 1'b0;
               pos_in          = '0;
               ram_rd_en       = 1'b1;
               ram_rd_addr     = '0;
               state_in        = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // write back every rank: insert, shift the carried entry, or keep
            ram_wr_en = 1'b1;
            if (!inserted_ff && (new_ff.strength > eff_entry.strength)) begin
               ram_wr_data = new_ff;
               carry_in    = eff_entry;
               inserted_in = 1'b1;
            end else if (inserted_ff) begin
               ram_wr_data = carry_ff;
               carry_in    = eff_entry;
            end else begin
               ram_wr_data = eff_entry;
            end
            if (pos_ff == LAST_POS) begin
               table_valid_in = 1'b1;
               pos_in         = '0;
               state_in       = last_ff ? ST_EMIT_RD : ST_IDLE;
            end else begin
               pos_in      = pos_ff + 1'b1;
               ram_rd_en   = 1'b1;
               ram_rd_addr = pos_ff + 1'b1;
            end
         end
         ST_EMIT_RD: begin
            // fetch the next rank once the output register will be free
            if (!rsp_valid_ff || rsp_tready) begin
               ram_rd_en = 1'b1;
               state_in  = ST_EMIT_WAIT;
            end
         end
         ST_EMIT_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {{PAD_W{1'b0}}, ram_rd_data.strength, ram_rd_data.freq,
                            RANK_W'(pos_ff)};
            rsp_last_in  = (pos_ff == LAST_POS);
            if (pos_ff == LAST_POS) begin
               state_in = ST_IDLE;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pos_ff         <= '0;
         inserted_ff    <= 1'b0;
         table_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         inserted_ff    <= inserted_in;
         table_valid_ff <= table_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff      <= new_in;
      carry_ff    <= carry_in;
      clear_ff    <= clear_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/tkrt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module tkrt_ram
   import tkrt_pkg::*;
#(
   parameter int  WIDTH  = ENTRY_W,
   parameter int  DEPTH  = TOP_COUNT_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tkrt_checker.sv =====
// Port-level checker of the ranked RSSI tracker, bound to the top level.
`timescale 1ns / 1ps
`include "top_k_rssi_tracker_top_macros.svh"

module tkrt_checker
   import tkrt_pkg::*;
#(
   parameter int TOP_COUNT = TOP_COUNT_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(TOP_COUNT - 1);

   // hold a stalled result beat
   `TKRT_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "stalled result beat changed")

   // the final rank of a table carries tlast
   `TKRT_ASSERT(a_last_rank, clock, reset,
      rsp_tvalid && rsp_tlast |-> rsp_tdata[RANK_W-1:0] == LAST_RANK,
      "tlast on a rank other than the final one")

   // an accepted beat starts a sweep, so no beat is taken right after it
   `TKRT_ASSERT(a_sweep_busy, clock, reset,
      req_tvalid && req_tready |=> !req_tready,
      "input taken during a table sweep")

   // an empty rank carries no frequency
   `TKRT_ASSERT(a_empty_rank, clock, reset,
      rsp_tvalid && rsp_tdata[26:19] == 8'd0 |-> rsp_tdata[18:3] == 16'd0,
      "empty rank with a nonzero frequency")

endmodule

bind top_k_rssi_tracker_top tkrt_checker #(
   .TOP_COUNT (TOP_COUNT)
) u_tkrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== dv/tb_top_k_rssi_tracker_top.sv =====
// Self-checking testbench of the ranked RSSI tracker top level.
`timescale 1ns / 1ps

module tb_top_k_rssi_tracker_top
   import tkrt_pkg::*;
();

   localparam int DEPTH       = TOP_COUNT_DEF;
   localparam int RANDOM_BEATS = 420;
   localparam int CYCLE_LIMIT = 200000;
   // settle time after the last result: about one full sweep plus the walk
   localparam int TAIL_CYCLES = 4 * DEPTH + 16;
   localparam int LONG_HOLD   = 400;

   // scan shapes of the random part
   typedef enum int {SCAN_FORMED, SCAN_NOISE} scan_kind_type;
   // strength mixes of the random part
   typedef enum int {MIX_FULL, MIX_TIES, MIX_LOW} strength_mix_type;

   typedef struct {
      logic [RANK_W-1:0] rank;
      logic [FREQ_W-1:0] freq;
      logic [RSSI_W-1:0] rssi;
      logic              last;
   } rank_beat_type;

   // Ranked-table predictor plus the queue of awaited rank beats.
   class rank_scoreboard_type;
      logic [RSSI_W-1:0] strength_tbl[DEPTH];
      logic [FREQ_W-1:0] freq_tbl[DEPTH];
      rank_beat_type     awaited[$];
      int                errors;
      int                checked;

      function new();
         for (int i = 0; i < DEPTH; i++) begin
            strength_tbl[i] = '0;
            freq_tbl[i]     = '0;
         end
         errors  = 0;
         checked = 0;
      endfunction

      // Apply one accepted reading to the table; queue the table on a last mark.
      function void note_input(bit first, bit last, logic [RSSI_W-1:0] rssi,
                               logic [FREQ_W-1:0] freq);
         bit            placed;
         rank_beat_type b;
         placed = 1'b0;
         if (first) begin
            for (int i = 0; i < DEPTH; i++) begin
               strength_tbl[i] = '0;
               freq_tbl[i]     = '0;
            end
         end
         for (int pos = 0; pos < DEPTH; pos++) begin
            if (!placed && rssi > strength_tbl[pos]) begin
               for (int k = DEPTH - 1; k > pos; k--) begin
                  strength_tbl[k] = strength_tbl[k-1];
                  freq_tbl[k]     = freq_tbl[k-1];
               end
               strength_tbl[pos] = rssi;
               freq_tbl[pos]     = freq;
               placed = 1'b1;
            end
         end
         if (last) begin
            for (int r = 0; r < DEPTH; r++) begin
               b.rank = r[RANK_W-1:0];
               b.freq = freq_tbl[r];
               b.rssi = strength_tbl[r];
               b.last = (r == DEPTH - 1);
               awaited.push_back(b);
            end
         end
      endfunction

      // Compare one result beat with the oldest awaited rank.
      function void check_result(logic [RSP_TDATA_W-1:0] tdata, logic tlast);
         rank_beat_type b;
         checked++;
         if (awaited.size() == 0) begin
            $error("result beat with nothing awaited: tdata=%h tlast=%b", tdata, tlast);
            errors++;
         end else begin
            b = awaited.pop_front();
            if (tdata[2:0] !== b.rank) begin
               $error("rank_index: expected %0d, got %0d", b.rank, tdata[2:0]);
               errors++;
            end
            if (tdata[18:3] !== b.freq) begin
               $error("top_frequency: expected %h, got %h", b.freq, tdata[18:3]);
               errors++;
            end
            if (tdata[26:19] !== b.rssi) begin
               $error("top_rssi: expected %0d, got %0d", b.rssi, tdata[26:19]);
               errors++;
            end
            if (tdata[RSP_TDATA_W-1:27] !== '0) begin
               $error("tdata pad: expected 0, got %h", tdata[RSP_TDATA_W-1:27]);
               errors++;
            end
            if (tlast !== b.last) begin
               $error("last_entry: expected %b, got %b", b.last, tlast);
               errors++;
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   // set by the sender over a stretch of the random part: no idling on either side
   bit quiet = 1'b0;
   int cycles = 0;

   rank_scoreboard_type sb = new();

   top_k_rssi_tracker_top #(.TOP_COUNT(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Bound the run; reaching the limit means the block hung.
   initial begin
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("top_k_rssi_tracker_top: mismatch");
      $finish;
   end

   // Check every result beat at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tlast);
   end

   // Drive rsp_tready: random idling, one long hold-off to back the block up.
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         // start the long hold once the random part is under way
         if (!hold_done && sb.checked >= 48) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 8);
         end
      end
   end

   // Offer one reading, idling at random first; return once it is accepted.
   task automatic send_reading(bit first, bit last, logic [RSSI_W-1:0] rssi,
                               logic [FREQ_W-1:0] freq);
      while (!quiet && $urandom_range(0, 99) < 8) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {freq, rssi};
      req_tuser  <= first;
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_input(first, last, rssi, freq);
   endtask

   // Drop valid and hold off until every awaited rank beat has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic logic [RSSI_W-1:0] pick_strength(strength_mix_type mix);
      logic [RSSI_W-1:0] v;
      case (mix)
         MIX_TIES: begin
            case ($urandom_range(0, 3))
               0:       v = 8'd0;
               1:       v = 8'd1;
               2:       v = 8'd128;
               default: v = 8'd255;
            endcase
         end
         MIX_LOW: begin
            v = RSSI_W'($urandom_range(0, 15));
         end
         default: begin
            v = RSSI_W'($urandom_range(0, 255));
         end
      endcase
      return v;
   endfunction

   function automatic logic [FREQ_W-1:0] pick_freq();
      logic [FREQ_W-1:0] f;
      case ($urandom_range(0, 15))
         0:       f = 16'h0000;
         1:       f = 16'hFFFF;
         default: f = FREQ_W'($urandom_range(0, 65535));
      endcase
      return f;
   endfunction

   initial begin
      int               sent;
      int               scan_no;
      int               scan_len;
      scan_kind_type    kind;
      strength_mix_type mix;
      bit               first;
      bit               last;

      sent    = 0;
      scan_no = 0;

      // hold reset, then release it on a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // no first mark since reset: table accumulates; zero reading skipped;
      // equal strength lands below the earlier channel
      send_reading(1'b0, 1'b0, 8'd100, 16'h1111);
      send_reading(1'b0, 1'b0, 8'd0,   16'h2222);
      send_reading(1'b0, 1'b1, 8'd100, 16'h3333);
      // both marks on one reading at the top extremes
      send_reading(1'b1, 1'b1, 8'd255, 16'hFFFF);
      // overfill the table so the weakest entries drop out
      send_reading(1'b1, 1'b0, 8'd0,   16'h0000);
      for (int i = 1; i <= 9; i++)
         send_reading(1'b0, 1'b0, RSSI_W'(i * 10), FREQ_W'(16'h0100 + i));
      send_reading(1'b0, 1'b1, 8'd255, 16'hABCD);
      // ties at the weak end, then a mid-range reading jumps above them
      send_reading(1'b1, 1'b0, 8'd1,   16'h8000);
      send_reading(1'b0, 1'b0, 8'd1,   16'h0001);
      send_reading(1'b0, 1'b1, 8'd128, 16'h7FFF);
      wait_drained();

      // --- random part: mostly whole scans, some scans with stray marks ---
      while (sent < RANDOM_BEATS) begin
         kind     = ($urandom_range(0, 99) < 85) ? SCAN_FORMED : SCAN_NOISE;
         mix      = strength_mix_type'($urandom_range(0, 2));
         scan_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 20);
         for (int i = 0; i < scan_len; i++) begin
            // no idling on either side for a stretch of the run
            quiet = (sent >= 150 && sent < 260);
            if (kind == SCAN_FORMED) begin
               first = (i == 0);
               last  = (i == scan_len - 1);
            end else begin
               first = ($urandom_range(0, 9) == 0);
               last  = ($urandom_range(0, 9) == 0);
            end
            send_reading(first, last, pick_strength(mix), pick_freq());
            sent++;
         end
         scan_no++;
         // now and then let the block run dry before the next scan
         if (scan_no % 12 == 6)
            wait_drained();
      end
      quiet = 1'b0;

      // --- drain ---
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("top_k_rssi_tracker_top: match");
      end else begin
         $display("top_k_rssi_tracker_top: mismatch");
      end
      $finish;
   end

endmodule
